// ----- hw/rtl/multilevel_feedback_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multilevel feedback scheduler
// Clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH

// concurrent assertion under the block clock and reset
`define MFS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("scheduler check failed");

// a condition that holds a signal for the next cycle
`define MFS_ASSERT_HOLD(lbl, cond, sig) \
	`MFS_ASSERT(lbl, (cond) |=> $stable(sig))

`endif

// ----- hw/rtl/mfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants, codes, types and helpers of the multilevel feedback
// scheduler
// ----------------------------------------------------------------------------
package mfs_pkg;

	// sizing
	localparam int MAX_LEVELS   = 8;
	localparam int QUEUE_DEPTH  = 16;
	localparam int LVL_W        = $clog2(MAX_LEVELS);
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W       = LVL_W + PTR_W;
	localparam int RAM_DEPTH    = MAX_LEVELS << PTR_W;
	localparam int ID_W         = 8;
	localparam int TIME_W       = 16;
	localparam int CFG_W        = 3;

	localparam logic [CFG_W-1:0] BOTTOM_RESET = 3'd3;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SELECT = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_CLAMPED = 2'd3;

	// per-request result, without the id read from the queue memory
	typedef struct packed {
		logic       found;
		logic       keep_running;
		logic [1:0] status;
		logic       any_waiting;
	} res_t;

	// queue memory access
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [ID_W-1:0]   wdata;
	} ram_req_t;

	// circular pointer advance within one level
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

endpackage

// ----- hw/rtl/mfs_ram.sv -----
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-address RAM, one write and one read per cycle,
// registered read data that holds until the next read
// ----------------------------------------------------------------------------
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		if (re)
			rdata <= mem_q[addr];
	end

endmodule

// ----- hw/rtl/mfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfs_ctrl
// Level bookkeeping: head, tail and fill count per level, remembered
// running level, command decode and queue memory request generation
// ----------------------------------------------------------------------------
module mfs_ctrl import mfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [CFG_W-1:0]  bottom_level,
	input  logic [1:0]        cmd,
	input  logic [ID_W-1:0]   proc_id,
	input  logic              is_new,
	input  logic [TIME_W-1:0] now_time,
	input  logic [TIME_W-1:0] selected_at,
	input  logic [TIME_W-1:0] done_before,
	input  logic [TIME_W-1:0] service_time,
	output res_t              res,
	output ram_req_t          ram_req
);

	logic [PTR_W-1:0] head_q [MAX_LEVELS];
	logic [PTR_W-1:0] tail_q [MAX_LEVELS];
	logic [CNT_W-1:0] cnt_q  [MAX_LEVELS];
	logic [LVL_W-1:0] run_lvl_q;
	logic             run_vld_q;

	logic [PTR_W-1:0] head_d [MAX_LEVELS];
	logic [PTR_W-1:0] tail_d [MAX_LEVELS];
	logic [CNT_W-1:0] cnt_d  [MAX_LEVELS];
	logic [LVL_W-1:0] run_lvl_d;
	logic             run_vld_d;

	logic [LVL_W-1:0] bottom;
	logic [MAX_LEVELS-1:0] nonempty;
	logic [MAX_LEVELS-1:0] nonempty_d;
	logic [LVL_W-1:0] pick_lvl;

	// bottom level clamped to the levels that exist
	assign bottom = ({1'b0, bottom_level} > (CFG_W + 1)'(MAX_LEVELS - 1))
		? LVL_W'(MAX_LEVELS - 1) : LVL_W'(bottom_level);

	// highest priority nonempty level
	always_comb begin
		pick_lvl = '0;
		for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
			nonempty[l] = (cnt_q[l] != '0);
			if (nonempty[l])
				pick_lvl = LVL_W'(l);
		end
	end

	// command decode and next state
	always_comb begin
		logic [LVL_W-1:0]  ins_lvl;
		logic [LVL_W-1:0]  q_lvl;
		logic [TIME_W-1:0] elapsed;
		logic              finished;

		head_d    = head_q;
		tail_d    = tail_q;
		cnt_d     = cnt_q;
		run_lvl_d = run_lvl_q;
		run_vld_d = run_vld_q;
		res       = '0;
		ram_req   = '0;
		ram_req.wdata = proc_id;
		ins_lvl   = '0;
		q_lvl     = run_vld_q ? run_lvl_q : '0;
		elapsed   = now_time - selected_at;
		finished  = ((done_before + elapsed) == service_time);

		case (cmd)
			CMD_INSERT: begin
				if (!is_new && run_vld_q) begin
					if (run_lvl_q >= bottom) begin
						ins_lvl    = bottom;
						res.status = ST_CLAMPED;
					end else begin
						ins_lvl = run_lvl_q + LVL_W'(1);
					end
				end
				if (cnt_q[ins_lvl] == CNT_W'(QUEUE_DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					ram_req.we       = go;
					ram_req.addr     = {ins_lvl, tail_q[ins_lvl]};
					tail_d[ins_lvl]  = ptr_next(tail_q[ins_lvl]);
					cnt_d[ins_lvl]   = cnt_q[ins_lvl] + CNT_W'(1);
				end
			end
			CMD_SELECT: begin
				if (|nonempty) begin
					ram_req.re       = go;
					ram_req.addr     = {pick_lvl, head_q[pick_lvl]};
					head_d[pick_lvl] = ptr_next(head_q[pick_lvl]);
					cnt_d[pick_lvl]  = cnt_q[pick_lvl] - CNT_W'(1);
					run_lvl_d        = pick_lvl;
					run_vld_d        = 1'b1;
					res.found        = 1'b1;
				end else begin
					res.status = ST_EMPTY;
				end
			end
			CMD_QUERY: begin
				if (finished)
					res.keep_running = 1'b0;
				else if (q_lvl >= bottom)
					res.keep_running = 1'b1;
				else
					res.keep_running = (elapsed < (TIME_W'(1) << q_lvl));
			end
			default: begin
			end
		endcase

		for (int l = 0; l < MAX_LEVELS; l++)
			nonempty_d[l] = (cnt_d[l] != '0);
		res.any_waiting = |nonempty_d;
	end

	// level state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < MAX_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
			run_lvl_q <= '0;
			run_vld_q <= 1'b0;
		end else if (go) begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			cnt_q     <= cnt_d;
			run_lvl_q <= run_lvl_d;
			run_vld_q <= run_vld_d;
		end
	end

endmodule

// ----- hw/rtl/multilevel_feedback_scheduler.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback ready-queue scheduler with FIFO levels in one RAM
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_stall with cmd, proc_id, is_new and the
//   time fields; a request is taken at an edge with in_valid high and
//   in_stall low. Each request gives exactly one result on the out_valid/
//   out_stall channel (found, sel_id, keep_running, status, any_waiting).
//   Config channel: cfg_valid/cfg_ready/cfg_data writes bottom_level;
//   cfg_ready is always high, write only while no request is in flight.
//   Result path: the queue RAM read starts at the accepting edge, and the
//   output register loads the read data when stage 1 advances.
//   Throughput: one request per cycle while the receiver takes results;
//   the queue RAM port and level pointers are updated in the accept cycle.
//   Receiver stall: the output register holds its result, the in-flight
//   stage waits behind it and in_stall rises until the output frees.
//   Reset: all levels empty, no running level, bottom_level = 3; the RAM
//   needs no clearing since only entries counted as present are read.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler import mfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [ID_W-1:0]   proc_id,
	input  logic              is_new,
	input  logic [TIME_W-1:0] now_time,
	input  logic [TIME_W-1:0] selected_at,
	input  logic [TIME_W-1:0] done_before,
	input  logic [TIME_W-1:0] service_time,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [ID_W-1:0]   sel_id,
	output logic              keep_running,
	output logic [1:0]        status,
	output logic              any_waiting
);

	logic [CFG_W-1:0] bottom_q;
	logic             accept;
	logic             adv;
	logic             valid_s1;
	res_t             res;
	res_t             res_s1;
	ram_req_t         ram_req;
	logic [ID_W-1:0]  rdata;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bottom_q <= BOTTOM_RESET;
		else if (cfg_valid && cfg_ready)
			bottom_q <= cfg_data;
	end

	// request handshake and stage advance
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	mfs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (accept),
		.bottom_level (bottom_q),
		.cmd          (cmd),
		.proc_id      (proc_id),
		.is_new       (is_new),
		.now_time     (now_time),
		.selected_at  (selected_at),
		.done_before  (done_before),
		.service_time (service_time),
		.res          (res),
		.ram_req      (ram_req)
	);

	mfs_ram #(
		.WIDTH (ID_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.re    (ram_req.re),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (rdata)
	);

	// stage 1: waiting for the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= res;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found        <= res_s1.found;
			sel_id       <= res_s1.found ? rdata : '0;
			keep_running <= res_s1.keep_running;
			status       <= res_s1.status;
			any_waiting  <= res_s1.any_waiting;
		end
	end

endmodule

// ----- hw/rtl/mfs_checker.sv -----
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks on the scheduler results, bound to the top level
// ----------------------------------------------------------------------------
`include "multilevel_feedback_scheduler_macros.svh"

module mfs_checker import mfs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              found,
	input logic [ID_W-1:0]   sel_id,
	input logic              keep_running,
	input logic [1:0]        status,
	input logic              any_waiting
);

	// a stalled result keeps its id
	`MFS_ASSERT_HOLD(a_sel_id_hold, out_valid && out_stall, sel_id)

	// a taken process always reports ok
	`MFS_ASSERT(a_found_ok, out_valid && found |-> status == ST_OK)

	// no id unless a process was taken
	`MFS_ASSERT(a_no_id, out_valid && !found |-> sel_id == '0)

	// select on empty means nothing waits
	`MFS_ASSERT(a_empty_none, out_valid && status == ST_EMPTY |-> !any_waiting && !keep_running)

	// input stalls only behind a stalled result
	`MFS_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall)

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.found        (found),
	.sel_id       (sel_id),
	.keep_running (keep_running),
	.status       (status),
	.any_waiting  (any_waiting)
);
